// File: hw/rtl/ssb_pkg.sv
// Shared types and register codes for the sub-pixel bilinear shift block.
package ssb_pkg;

	// Configuration register codes, one per register of the block.
	localparam logic [2:0] REG_FRAC_X        = 3'd0;
	localparam logic [2:0] REG_FRAC_Y        = 3'd1;
	localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
	localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd3;
	localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd4;

	// Widths of the configuration port.
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 12;

	// Control that travels with a source byte down the pipeline.
	typedef struct packed {
		logic emit;
		logic row_end;
		logic frame_end;
	} ssb_tag_t;

endpackage

// File: hw/rtl/ssb_line_mem.sv
// Single-port-write, single-port-read line memory with a registered read.
module ssb_line_mem #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read is before write when both hit the same entry; the caller forwards.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hw/rtl/subpixel_shift_bilinear_top.sv
// Top level of the sub-pixel bilinear shift block: counters, neighbor delays and datapath.
//
// Source bytes of an interleaved 8-bit image enter on the sample channel in raster
// order over a window one pixel wider when frac_x is nonzero and one row taller when
// frac_y is nonzero. Each accepted request may produce one output request on the
// pixel channel, carrying the interpolated byte with row_end and frame_end flags.
// Bytes of the extra first row and the first channel_count bytes of each row when
// shifting horizontally produce no output.
// The previous source row lives in a line memory with a registered read; each byte
// reads the entry of its column when accepted and writes its own value back from stage 1
// as it moves on, with a forwarding path when a one-byte row makes consecutive bytes meet.
// Throughput is one byte per clock while the receiver does not stall. An accepted request
// passes the memory read, the multiply stage and the sum into the output register
// before its output request is presented on the pixel channel.
// When the receiver stalls, the pipeline holds and sample_ready drops only once every
// stage is full. Reset clears the counters, the pipeline valid bits and restores the
// registers to zero fractions, one channel, width one and height one. The line memory
// and the delay lines are not cleared; a frame fills them before reading them.
// Configuration writes take effect at once and belong between frames.
module subpixel_shift_bilinear_top #(
	parameter int unsigned MAX_ROW_BYTES = 4096,
	parameter int unsigned MAX_CHANNELS  = 4,
	parameter int unsigned FRACTION_BITS = 4,
	parameter int unsigned MAX_HEIGHT    = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ssb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ssb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                           sample_valid,
	output logic                           sample_ready,
	input  logic [7:0]                     sample,
	output logic                           pixel_valid,
	input  logic                           pixel_ready,
	output logic [7:0]                     pixel,
	output logic                           row_end,
	output logic                           frame_end
);

	import ssb_pkg::*;

	// Column and row counter widths; the source row and row count never exceed the maxima.
	localparam int unsigned CW  = $clog2(MAX_ROW_BYTES);
	localparam int unsigned RW  = $clog2(MAX_HEIGHT);
	localparam int unsigned SW  = (CW + 1 > 14) ? CW + 1 : 14;
	localparam int unsigned RSW = (RW + 1 > 13) ? RW + 1 : 13;
	localparam int unsigned TW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int unsigned F   = FRACTION_BITS;
	localparam int unsigned WW  = 2 * F + 1;
	localparam int unsigned PW  = 2 * F + 9;
	localparam logic [F:0]    RANGE = (F + 1)'(1 << F);
	localparam logic [PW-1:0] HALF  = PW'(1 << (2 * F - 1));

	// Configuration registers.
	logic [3:0]  frac_x_q;
	logic [3:0]  frac_y_q;
	logic [2:0]  chan_q;
	logic [9:0]  width_q;
	logic [11:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_x_q <= '0;
			frac_y_q <= '0;
			chan_q   <= 3'd1;
			width_q  <= 10'd1;
			height_q <= 12'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAC_X:        frac_x_q <= cfg_data[3:0];
				REG_FRAC_Y:        frac_y_q <= cfg_data[3:0];
				REG_CHANNEL_COUNT: chan_q   <= cfg_data[2:0];
				REG_IMAGE_WIDTH:   width_q  <= cfg_data[9:0];
				REG_IMAGE_HEIGHT:  height_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// Effective geometry from the registers.
	logic [F-1:0]   fx;
	logic [F-1:0]   fy;
	logic           ex;
	logic           ey;
	logic [2:0]     ch_eff;
	logic [TW-1:0]  tap;
	logic [9:0]     w_eff;
	logic [11:0]    h_eff;
	logic [13:0]    row_bytes;
	logic [12:0]    rows_raw;
	logic [SW-1:0]  src_bytes;
	logic [RSW-1:0] src_rows;
	logic [2:0]     skip_bytes;

	assign fx     = frac_x_q[F-1:0];
	assign fy     = frac_y_q[F-1:0];
	assign ex     = (fx != '0);
	assign ey     = (fy != '0);
	assign ch_eff = (chan_q == 3'd0) ? 3'd1 :
	                (chan_q > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : chan_q;
	assign tap    = TW'(ch_eff - 3'd1);
	assign w_eff  = (width_q == '0) ? 10'd1 : width_q;
	assign h_eff  = (height_q == '0) ? 12'd1 : height_q;

	assign row_bytes = 14'(({1'b0, w_eff} + {10'd0, ex}) * {11'd0, ch_eff});
	assign rows_raw  = {1'b0, h_eff} + {12'd0, ey};
	assign src_bytes = (SW'(row_bytes) > SW'(MAX_ROW_BYTES)) ? SW'(MAX_ROW_BYTES)
	                                                         : SW'(row_bytes);
	assign src_rows  = (RSW'(rows_raw) > RSW'(MAX_HEIGHT)) ? RSW'(MAX_HEIGHT)
	                                                       : RSW'(rows_raw);
	assign skip_bytes = ex ? ch_eff : 3'd0;

	// Tap weights: horizontal left/right times vertical top/bottom. A zero fraction
	// puts the full weight on the right column or bottom row.
	logic [F:0]    hl, hr, vt, vb;
	logic [WW-1:0] w_diag, w_above, w_left, w_samp;

	assign hl      = ex ? RANGE - {1'b0, fx} : '0;
	assign hr      = ex ? {1'b0, fx} : RANGE;
	assign vt      = ey ? RANGE - {1'b0, fy} : '0;
	assign vb      = ey ? {1'b0, fy} : RANGE;
	assign w_diag  = WW'(hl) * WW'(vt);
	assign w_above = WW'(hr) * WW'(vt);
	assign w_left  = WW'(hl) * WW'(vb);
	assign w_samp  = WW'(hr) * WW'(vb);

	// Pipeline handshake.
	logic accept;
	logic valid_s1, valid_s2, out_valid_q;
	logic s1_go, s2_go, s2_free, out_free;
	ssb_tag_t tag_s1, tag_s2, tag_now;

	assign out_free     = !out_valid_q || pixel_ready;
	assign s2_go        = valid_s2 && (!tag_s2.emit || out_free);
	assign s2_free      = !valid_s2 || s2_go;
	assign s1_go        = valid_s1 && s2_free;
	assign sample_ready = !valid_s1 || s1_go;
	assign accept       = sample_valid && sample_ready;

	// Source position counters.
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          last_col, last_row;

	assign last_col = (SW'(col_q) + SW'(1)) >= src_bytes;
	assign last_row = (RSW'(row_q) + RSW'(1)) >= src_rows;

	assign tag_now.emit      = (col_q >= CW'(skip_bytes)) && (row_q >= RW'(ey));
	assign tag_now.row_end   = last_col;
	assign tag_now.frame_end = last_col && last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Stage 1: line memory read returns; forward when the previous byte wrote the same entry.
	logic [CW-1:0]  idx_s1;
	logic [7:0]     sample_s1;
	logic [7:0]     fwd_data_s1;
	logic           fwd_s1;
	logic [WW-1:0]  w_diag_s1, w_above_s1, w_left_s1, w_samp_s1;
	logic [7:0]     mem_rd;
	logic [7:0]     above_s1;
	logic [7:0]     left_s1;
	logic [7:0]     diag_s1;
	logic [7:0]     cur_dly_q  [MAX_CHANNELS];
	logic [7:0]     prev_dly_q [MAX_CHANNELS];

	ssb_line_mem #(
		.DEPTH (MAX_ROW_BYTES),
		.AW    (CW)
	) u_line_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (mem_rd),
		.wr_en   (s1_go),
		.wr_addr (idx_s1),
		.wr_data (sample_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1      <= col_q;
			sample_s1   <= sample;
			tag_s1      <= tag_now;
			fwd_s1      <= s1_go && (idx_s1 == col_q);
			fwd_data_s1 <= sample_s1;
			w_diag_s1   <= w_diag;
			w_above_s1  <= w_above;
			w_left_s1   <= w_left;
			w_samp_s1   <= w_samp;
		end
	end

	assign above_s1 = fwd_s1 ? fwd_data_s1 : mem_rd;
	assign left_s1  = cur_dly_q[tap];
	assign diag_s1  = prev_dly_q[tap];

	// Channel delays: same-row and previous-row bytes one pixel back.
	always_ff @(posedge clk) begin
		if (s1_go) begin
			for (int i = MAX_CHANNELS - 1; i > 0; i--) begin
				cur_dly_q[i]  <= cur_dly_q[i-1];
				prev_dly_q[i] <= prev_dly_q[i-1];
			end
			cur_dly_q[0]  <= sample_s1;
			prev_dly_q[0] <= above_s1;
		end
	end

	// Stage 2: four products registered. A tap with zero weight contributes zero even
	// when its neighbor entry has not been written yet in this frame.
	logic [PW-1:0] p_diag_s2, p_above_s2, p_left_s2, p_samp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			tag_s2     <= tag_s1;
			p_diag_s2  <= (w_diag_s1 == '0) ? '0 : PW'(w_diag_s1) * PW'(diag_s1);
			p_above_s2 <= (w_above_s1 == '0) ? '0 : PW'(w_above_s1) * PW'(above_s1);
			p_left_s2  <= (w_left_s1 == '0) ? '0 : PW'(w_left_s1) * PW'(left_s1);
			p_samp_s2  <= PW'(w_samp_s1) * PW'(sample_s1);
		end
	end

	// Sum with rounding; the weights always add to the full scale.
	logic [PW-1:0] sum_s2;

	assign sum_s2 = p_diag_s2 + p_above_s2 + p_left_s2 + p_samp_s2 + HALF;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s2_go && tag_s2.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s2_go && tag_s2.emit) begin
			pixel     <= sum_s2[2*F+7:2*F];
			row_end   <= tag_s2.row_end;
			frame_end <= tag_s2.frame_end;
		end
	end

	assign pixel_valid = out_valid_q;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sub-pixel bilinear shift block, with its own predictor.
module testbench;
	import ssb_pkg::*;

	// These mirror the block's parameters. They are passed to the instance so that the
	// predictor and the hardware agree on every size limit.
	localparam int unsigned ROW_BYTES_LIMIT = 4096;
	localparam int unsigned CHANNEL_LIMIT   = 4;
	localparam int unsigned FRAC_BITS       = 4;
	localparam int unsigned ROW_LIMIT       = 4096;
	localparam int unsigned FRAC_ONE        = 1 << FRAC_BITS;

	// A request passes stage 1, stage 2 and the output register before its output is presented.
	// A few more cycles of drain are allowed before any register write and at the end of the run.
	localparam int unsigned DRAIN_CYCLES    = 8;
	localparam int unsigned RANDOM_SAMPLES  = 800;
	// The slowest correct run is set by the bytes sent, the receiver's stall pattern, sender
	// gaps and drains. The limit leaves a wide margin.
	localparam int unsigned CYCLE_LIMIT     = 2_000_000;
	localparam int unsigned PRINT_LIMIT     = 100;

	// Sample selection for a frame: fully random bytes, or only the two extremes.
	localparam int SAMPLES_RANDOM  = 0;
	localparam int SAMPLES_EXTREME = 1;

	typedef struct packed {
		logic [7:0] value;
		logic       row_end;
		logic       frame_end;
	} shifted_pixel_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   sample_valid;
	logic                   sample_ready;
	logic [7:0]             sample;
	logic                   pixel_valid;
	logic                   pixel_ready;
	logic [7:0]             pixel;
	logic                   row_end;
	logic                   frame_end;

	subpixel_shift_bilinear_top #(
		.MAX_ROW_BYTES(ROW_BYTES_LIMIT),
		.MAX_CHANNELS (CHANNEL_LIMIT),
		.FRACTION_BITS(FRAC_BITS),
		.MAX_HEIGHT   (ROW_LIMIT)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample      (sample),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel),
		.row_end     (row_end),
		.frame_end   (frame_end)
	);

	// Shadow copy of the register file, kept at the widths of the registers so that
	// the upper bits of a write are dropped exactly as the hardware drops them.
	logic [3:0]  frac_x_setting;
	logic [3:0]  frac_y_setting;
	logic [2:0]  channel_setting;
	logic [9:0]  width_setting;
	logic [11:0] height_setting;

	// Predictor state: the previous source row, the two short neighbor delays and the
	// position within the source window.
	logic [7:0]  upper_row [ROW_BYTES_LIMIT];
	logic [7:0]  left_delay [CHANNEL_LIMIT];
	logic [7:0]  diagonal_delay [CHANNEL_LIMIT];
	int unsigned column_pos;
	int unsigned row_pos;

	// Output requests that the predictor expects, oldest first.
	shifted_pixel_t pending_pixels [$];

	int unsigned mismatch_count = 0;
	int unsigned samples_sent = 0;
	int unsigned cycle_count = 0;
	int          burst_left = 0;
	int          gap_limit = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// A channel count of zero acts as one pixel byte, anything above the limit as the limit.
	function automatic int unsigned effective_channels();
		int unsigned ch;
		ch = channel_setting;
		if (ch == 0)
			ch = 1;
		if (ch > CHANNEL_LIMIT)
			ch = CHANNEL_LIMIT;
		return ch;
	endfunction

	// Bytes per source row: one extra pixel when shifting horizontally, capped at the
	// line memory size. A width of zero counts as one pixel.
	function automatic int unsigned window_bytes();
		int unsigned n;
		n = (width_setting == 0) ? 1 : width_setting;
		n = (n + ((frac_x_setting != 0) ? 1 : 0)) * effective_channels();
		return (n > ROW_BYTES_LIMIT) ? ROW_BYTES_LIMIT : n;
	endfunction

	// Source rows per frame: one extra row when shifting vertically, capped at the limit.
	function automatic int unsigned window_rows();
		int unsigned n;
		n = (height_setting == 0) ? 1 : height_setting;
		n = n + ((frac_y_setting != 0) ? 1 : 0);
		return (n > ROW_LIMIT) ? ROW_LIMIT : n;
	endfunction

	// Advances the predictor by one accepted source byte. The incoming byte is the lower
	// right neighbor; the line memory gives the byte above it, and the delays give the
	// byte one pixel to the left in both rows.
	function automatic void predict_shifted_pixel(input logic [7:0] s);
		int unsigned fx, fy, ch, ex, ey, idx, acc;
		logic [7:0] above, left, diag, result;
		logic last_col, last_row;
		fx = frac_x_setting;
		fy = frac_y_setting;
		ch = effective_channels();
		ex = (fx != 0) ? 1 : 0;
		ey = (fy != 0) ? 1 : 0;
		idx = (column_pos < ROW_BYTES_LIMIT) ? column_pos : ROW_BYTES_LIMIT - 1;
		above = upper_row[idx];
		left = left_delay[ch - 1];
		diag = diagonal_delay[ch - 1];

		if (fx != 0 && fy != 0) begin
			acc = (FRAC_ONE - fx) * (FRAC_ONE - fy) * diag + fx * (FRAC_ONE - fy) * above
				+ (FRAC_ONE - fx) * fy * left + fx * fy * s + (1 << (2 * FRAC_BITS - 1));
			result = 8'(acc >> (2 * FRAC_BITS));
		end else if (fx != 0) begin
			acc = (FRAC_ONE - fx) * left + fx * s + (1 << (FRAC_BITS - 1));
			result = 8'(acc >> FRAC_BITS);
		end else if (fy != 0) begin
			acc = (FRAC_ONE - fy) * above + fy * s + (1 << (FRAC_BITS - 1));
			result = 8'(acc >> FRAC_BITS);
		end else begin
			result = s;
		end

		for (int i = CHANNEL_LIMIT - 1; i > 0; i--) begin
			left_delay[i] = left_delay[i - 1];
			diagonal_delay[i] = diagonal_delay[i - 1];
		end
		left_delay[0] = s;
		diagonal_delay[0] = above;
		upper_row[idx] = s;

		// A position already at or past the end of the window ends its row or frame,
		// which is what happens when the size shrinks in the middle of a frame.
		last_col = (column_pos + 1 >= window_bytes());
		last_row = (row_pos + 1 >= window_rows());

		// The first source row of a vertical shift and the first pixel of each row of a
		// horizontal shift only fill the neighbor stores.
		if (column_pos >= ex * ch && row_pos >= ey)
			pending_pixels.push_back('{value: result, row_end: last_col,
				frame_end: last_col && last_row});

		if (last_col) begin
			column_pos = 0;
			row_pos = last_row ? 0 : row_pos + 1;
		end else begin
			column_pos = column_pos + 1;
		end
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned wanted);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, wanted);
	endtask

	// Sends one source byte and waits for its request to be accepted. The sender works
	// in bursts; between bursts it drops valid for a random number of cycles, up to
	// gap_limit. Valid is only lowered when a real gap follows, so it never drops and
	// rises within one step. Returns at the falling edge after the acceptance.
	task automatic push_sample(input logic [7:0] value);
		int gap;
		if (burst_left <= 0) begin
			gap = (gap_limit > 0) ? $urandom_range(0, gap_limit) : 0;
			if (gap > 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		sample_valid <= 1'b1;
		sample <= value;
		@(posedge clk);
		while (sample_ready !== 1'b1)
			@(posedge clk);
		predict_shifted_pixel(value);
		samples_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	// Sends one whole source window. It must start with the predictor at the head of a
	// frame, so that every neighbor read finds data of the current configuration.
	task automatic send_frame(input int selection);
		int unsigned n;
		n = window_bytes() * window_rows();
		repeat (n) begin
			if (selection == SAMPLES_EXTREME)
				push_sample(($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00);
			else
				push_sample(8'($urandom));
		end
	endtask

	// Lets the block go idle: no request in flight, every output delivered, and a few
	// cycles more for bytes that produce no output.
	task automatic wait_idle();
		sample_valid <= 1'b0;
		burst_left = 0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// One register write; the shadow copy is updated along with it. The caller lowers
	// the write enable after the last write of a group.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		case (index)
			REG_FRAC_X: frac_x_setting = data[3:0];
			REG_FRAC_Y: frac_y_setting = data[3:0];
			REG_CHANNEL_COUNT: channel_setting = data[2:0];
			REG_IMAGE_WIDTH: width_setting = data[9:0];
			REG_IMAGE_HEIGHT: height_setting = data[11:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Waits for the block to drain, then writes all five registers with raw port values.
	task automatic configure(input logic [11:0] fx, input logic [11:0] fy,
		input logic [11:0] ch, input logic [11:0] w, input logic [11:0] h);
		wait_idle();
		write_reg(REG_FRAC_X, fx);
		write_reg(REG_FRAC_Y, fy);
		write_reg(REG_CHANNEL_COUNT, ch);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		cfg_we <= 1'b0;
	endtask

	// Puts random junk above a register's width now and then; the block must drop it.
	function automatic logic [11:0] with_upper_noise(input int unsigned value,
		input int unsigned bits);
		logic [31:0] noise;
		noise = ($urandom_range(0, 3) == 0) ? ($urandom << bits) : 32'd0;
		return 12'(value | noise);
	endfunction

	// Straight after reset the block copies a one-byte frame.
	task automatic test_reset_defaults();
		gap_limit = 0;
		send_frame(SAMPLES_EXTREME);
		send_frame(SAMPLES_EXTREME);
	endtask

	// Both fractions zero: three-channel bytes are passed through unchanged.
	task automatic test_copy();
		configure(0, 0, 3, 2, 1);
		gap_limit = 3;
		send_frame(SAMPLES_EXTREME);
	endtask

	// Largest horizontal fraction alone: two-tap filter along the row, and the first
	// pixel of each row gives no output.
	task automatic test_horizontal();
		configure(15, 0, 1, 3, 2);
		gap_limit = 2;
		send_frame(SAMPLES_EXTREME);
	endtask

	// Smallest vertical fraction alone: the first source row gives no output.
	task automatic test_vertical();
		configure(0, 1, 2, 2, 1);
		gap_limit = 1;
		send_frame(SAMPLES_EXTREME);
	endtask

	// Both fractions nonzero: four-tap weighting with the wider rounding.
	task automatic test_bilinear();
		configure(8, 15, 1, 2, 1);
		gap_limit = 0;
		send_frame(SAMPLES_EXTREME);
	endtask

	// Out-of-range register contents: bits above the width of each register narrower
	// than the port, a channel count of zero and above the limit, zero width and height,
	// and the one-byte row where each byte meets the line memory write of the byte just before it.
	task automatic test_register_coding();
		gap_limit = 2;
		configure(12'h135, 12'h0F0, 12'h000, 12'h000, 12'h000);
		send_frame(SAMPLES_EXTREME);
		configure(12'h000, 12'h07A, 12'h006, 12'h001, 12'h001);
		send_frame(SAMPLES_RANDOM);
		configure(12'h000, 12'hFF3, 12'hFF9, 12'hC01, 12'h003);
		send_frame(SAMPLES_RANDOM);
		configure(12'h00F, 12'h00F, 12'h007, 12'h001, 12'h001);
		send_frame(SAMPLES_EXTREME);
	endtask

	// Sizes shrunk in the middle of a frame, in copy mode so that no stale neighbor is
	// read. A column already past the new row length ends the row at once, and a row
	// already past the new height ends the frame on its last byte.
	task automatic test_midframe_change();
		gap_limit = 1;
		configure(0, 0, 1, 6, 3);
		repeat (4) push_sample(8'($urandom));
		configure(0, 0, 1, 2, 3);
		repeat (3) push_sample(8'($urandom));
		configure(0, 0, 1, 2, 1);
		repeat (2) push_sample(8'($urandom));
	endtask

	// Random settings, mostly small frames with a few wide rows, one to three frames
	// per setting. Some settings run the sender without gaps at all.
	task automatic test_random_frames();
		int unsigned start, fx, fy, ch, w, h;
		int selection;
		start = samples_sent;
		while (samples_sent - start < RANDOM_SAMPLES) begin
			fx = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			fy = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			ch = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
			h = $urandom_range(0, 5);
			configure(with_upper_noise(fx, 4), with_upper_noise(fy, 4),
				with_upper_noise(ch, 3), with_upper_noise(w, 10), with_upper_noise(h, 12));
			gap_limit = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			repeat ($urandom_range(1, 3)) begin
				selection = ($urandom_range(0, 4) == 0) ? SAMPLES_EXTREME : SAMPLES_RANDOM;
				send_frame(selection);
			end
		end
	endtask

	// A wide row of four-channel pixels with both shifts, reaching deep into the line
	// memory, and a tall frame of one-byte rows.
	task automatic test_size_extremes();
		gap_limit = 2;
		configure(7, 9, 4, 63, 1);
		send_frame(SAMPLES_RANDOM);
		configure(0, 3, 1, 1, 255);
		send_frame(SAMPLES_RANDOM);
	endtask

	// The receiver stalls on a rotating 16-bit pattern that is redrawn when its random
	// age runs out. A quarter of the patterns never stall; every pattern has at least one
	// ready cycle.
	initial begin
		logic [15:0] stall_pattern;
		int pattern_age;
		pixel_ready = 1'b0;
		stall_pattern = 16'hFFFF;
		pattern_age = 0;
		forever begin
			@(negedge clk);
			if (pattern_age == 0) begin
				pattern_age = $urandom_range(50, 300);
				stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
			end
			pattern_age--;
			pixel_ready <= stall_pattern[0];
			stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
		end
	end

	// Every accepted output request is checked against the oldest expectation.
	always @(posedge clk) begin
		shifted_pixel_t want;
		if (arst_n && pixel_valid === 1'b1 && pixel_ready) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("output request with nothing expected", pixel, 0);
			end else begin
				want = pending_pixels.pop_front();
				if (pixel !== want.value)
					report_mismatch("pixel", pixel, want.value);
				if (row_end !== want.row_end)
					report_mismatch("row_end", row_end, want.row_end);
				if (frame_end !== want.frame_end)
					report_mismatch("frame_end", frame_end, want.frame_end);
			end
		end
	end

	// Watchdog against a hang anywhere in the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("subpixel_shift_bilinear_top test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FRAC_X;
		cfg_data = '0;
		sample_valid = 1'b0;
		sample = '0;

		// Predictor state after reset. The stores start at zero here; the hardware's are
		// unknown, but no test reads an entry before the current frame has written it.
		frac_x_setting = '0;
		frac_y_setting = '0;
		channel_setting = 3'd1;
		width_setting = 10'd1;
		height_setting = 12'd1;
		column_pos = 0;
		row_pos = 0;
		for (int i = 0; i < ROW_BYTES_LIMIT; i++)
			upper_row[i] = '0;
		for (int i = 0; i < CHANNEL_LIMIT; i++) begin
			left_delay[i] = '0;
			diagonal_delay[i] = '0;
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_copy();
		test_horizontal();
		test_vertical();
		test_bilinear();
		test_register_coding();
		test_midframe_change();
		test_random_frames();
		test_size_extremes();

		// Drain: every expected output has arrived, then a few quiet cycles in which any
		// stray output request would still be caught by the checker.
		wait_idle();

		if (mismatch_count == 0)
			$display("subpixel_shift_bilinear_top test passed");
		else
			$display("subpixel_shift_bilinear_top test failed");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/ssb_pkg.sv
hw/rtl/ssb_line_mem.sv
hw/rtl/subpixel_shift_bilinear_top.sv
tb/sv/testbench.sv
